// ===== rtl/cdll_pkg.sv =====
// package for the circular doubly linked list engine
// holds sizes, function and status codes and the request/response types
package cdll_pkg;

  localparam int unsigned Capacity  = 32;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned SlotW     = $clog2(Capacity);
  localparam int unsigned CountW    = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    FnInsFront = 3'd0,
    FnInsBack  = 3'd1,
    FnInsAt    = 3'd2,
    FnDelFront = 3'd3,
    FnDelBack  = 3'd4,
    FnDelAt    = 3'd5,
    FnSearch   = 3'd6,
    FnNop      = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StEmpty    = 3'd1,
    StBadPos   = 3'd2,
    StNotFound = 3'd3,
    StFull     = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]        func;
    logic [5:0]        position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         found_index;
    logic [5:0]         element_count;
  } rsp_t;

endpackage

// ===== rtl/cdll_if.sv =====
// valid/ready channel interface carrying one payload
// depends on cdll_pkg for payload types
interface cdll_req_if import cdll_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cdll_rsp_if import cdll_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/cdll_node_mem.sv =====
// node pool store: value, next and prev arrays, one write per array per cycle
// read data registered; depends on cdll_pkg
module cdll_node_mem import cdll_pkg::*; (
  input  logic                 clk_i,
  input  logic [SlotW-1:0]     rd_addr_i,
  output logic [DataWidth-1:0] rd_val_o,
  output logic [SlotW-1:0]     rd_next_o,
  output logic [SlotW-1:0]     rd_prev_o,
  input  logic                 val_we_i,
  input  logic [SlotW-1:0]     val_addr_i,
  input  logic [DataWidth-1:0] val_data_i,
  input  logic                 nxt_we_i,
  input  logic [SlotW-1:0]     nxt_addr_i,
  input  logic [SlotW-1:0]     nxt_data_i,
  input  logic                 prv_we_i,
  input  logic [SlotW-1:0]     prv_addr_i,
  input  logic [SlotW-1:0]     prv_data_i
);

  logic [DataWidth-1:0] val_mem [Capacity];
  logic [SlotW-1:0]     nxt_mem [Capacity];
  logic [SlotW-1:0]     prv_mem [Capacity];

  always_ff @(posedge clk_i) begin
    if (val_we_i) val_mem[val_addr_i] <= val_data_i;
    if (nxt_we_i) nxt_mem[nxt_addr_i] <= nxt_data_i;
    if (prv_we_i) prv_mem[prv_addr_i] <= prv_data_i;
    rd_val_o  <= val_mem[rd_addr_i];
    rd_next_o <= nxt_mem[rd_addr_i];
    rd_prev_o <= prv_mem[rd_addr_i];
  end

endmodule

// ===== rtl/circular_doubly_linked_list_engine.sv =====
// circular doubly linked list engine, top level with sequencer
// depends on cdll_pkg, cdll_if and cdll_node_mem
// rejected or unused ops go straight to their response; front/back ops reach their node
// from the head or, for the tail, by one backward link; positional ops and search walk
// one link per registered memory read (SWaitA, SWalk), up to the list length
// one operation at a time, next transfer taken from the cycle the response becomes valid;
// a finished response waits in its own output register, the sequencer only stalls
// when a newer response is ready while the older one is still waiting
// reset clears head, count and free map; node memory contents are not reset
module circular_doubly_linked_list_engine import cdll_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  cdll_req_if.sink  req_i,
  cdll_rsp_if.source rsp_o
);

  typedef enum logic [8:0] {
    SIdle  = 9'b000000001,
    SRdA   = 9'b000000010,
    SWaitA = 9'b000000100,
    SWalk  = 9'b000001000,
    SRdB   = 9'b000010000,
    SWaitB = 9'b000100000,
    SIns   = 9'b001000000,
    SDel   = 9'b010000000,
    SDone  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [Capacity-1:0] free_q, free_d;
  logic [SlotW-1:0]    head_q, head_d;
  logic [CountW-1:0]   len_q, len_d;
  logic [2:0]          func_q;
  logic [CountW-1:0]   pos_q;
  logic [DataWidth-1:0] val_q;
  logic [SlotW-1:0]    cur_q, cur_d;      // walk pointer / target slot
  logic [CountW-1:0]   steps_q, steps_d;  // remaining walk steps or search index
  logic                ins_q, ins_d;      // walking for insert vs delete
  logic [SlotW-1:0]    p_q, p_d, n_q, n_d;
  logic [SlotW-1:0]    new_slot;
  logic                rsp_valid_q;
  rsp_t                rsp_q, rsp_d;
  rsp_t                rsp_out_q;
  logic                rsp_load;

  logic [SlotW-1:0]     rd_addr;
  logic [DataWidth-1:0] rd_val;
  logic [SlotW-1:0]     rd_next, rd_prev;
  logic                 val_we, nxt_we, prv_we;
  logic [SlotW-1:0]     val_addr, nxt_addr, nxt_data, prv_addr, prv_data;

  cdll_node_mem u_mem (
    .clk_i,
    .rd_addr_i (rd_addr),
    .rd_val_o  (rd_val),
    .rd_next_o (rd_next),
    .rd_prev_o (rd_prev),
    .val_we_i  (val_we),
    .val_addr_i(val_addr),
    .val_data_i(val_q),
    .nxt_we_i  (nxt_we),
    .nxt_addr_i(nxt_addr),
    .nxt_data_i(nxt_data),
    .prv_we_i  (prv_we),
    .prv_addr_i(prv_addr),
    .prv_data_i(prv_data)
  );

  // lowest free slot
  always_comb begin
    new_slot = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (free_q[i]) new_slot = SlotW'(i);
    end
  end

  assign req_i.ready = (state_q == SIdle);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_out_q;

  always_comb begin
    state_d  = state_q;
    free_d   = free_q;
    head_d   = head_q;
    len_d    = len_q;
    cur_d    = cur_q;
    steps_d  = steps_q;
    ins_d    = ins_q;
    p_d      = p_q;
    n_d      = n_q;
    rsp_d    = rsp_q;
    rsp_load = 1'b0;
    rd_addr  = cur_q;
    val_we   = 1'b0;
    nxt_we   = 1'b0;
    prv_we   = 1'b0;
    val_addr = new_slot;
    nxt_addr = '0;
    nxt_data = '0;
    prv_addr = '0;
    prv_data = '0;
    case (state_q)
      SIdle: begin
        if (req_i.valid && req_i.ready) begin
          state_d = SRdA;
          cur_d   = head_q;
        end
      end
      SRdA: begin
        // decode and start first read (head) where needed
        rsp_d = '0;
        rsp_d.element_count = len_q;
        state_d = SWaitA;
        case (func_q)
          FnInsFront, FnInsBack, FnInsAt: begin
            logic [CountW-1:0] at;
            at = (func_q == FnInsFront) ? '0 :
                 (func_q == FnInsBack) ? len_q : pos_q;
            if (at > len_q) begin
              rsp_d.status = StBadPos; state_d = SDone;
            end else if (len_q >= CountW'(Capacity)) begin
              rsp_d.status = StFull; state_d = SDone;
            end else if (len_q == '0) begin
              state_d = SIns; p_d = new_slot; n_d = new_slot;
            end else begin
              ins_d = 1'b1;
              // insert after node at index at-1; at==0 is after the tail
              steps_d = (at == '0) ? len_q - 1'b1 : at - 1'b1;
            end
          end
          FnDelFront, FnDelBack, FnDelAt: begin
            if (len_q == '0) begin
              rsp_d.status = StEmpty; state_d = SDone;
            end else if (func_q == FnDelAt &&
                         (pos_q == '0 || pos_q > len_q)) begin
              rsp_d.status = StBadPos; state_d = SDone;
            end else begin
              ins_d = 1'b0;
              steps_d = (func_q == FnDelFront) ? '0 :
                        (func_q == FnDelBack) ? len_q - 1'b1 : pos_q - 1'b1;
            end
          end
          FnSearch: begin
            if (len_q == '0) begin
              rsp_d.status = StEmpty; state_d = SDone;
            end else begin
              rsp_d.status = StNotFound; steps_d = '0;
            end
          end
          default: state_d = SDone;
        endcase
      end
      SWaitA: state_d = SWalk;  // read data for cur_q is now valid
      SWalk: begin
        if (func_q == FnSearch) begin
          if (rd_val == val_q) begin
            rsp_d.status = StOk;
            rsp_d.found_index = steps_q[SlotW-1:0];
            state_d = SDone;
          end else if (steps_q + 1'b1 == len_q) begin
            state_d = SDone;
          end else begin
            steps_d = steps_q + 1'b1;
            cur_d = rd_next; rd_addr = rd_next; state_d = SWaitA;
          end
        end else if (steps_q != '0) begin
          // shortcut backwards for the tail
          if (steps_q == len_q - 1'b1) begin
            cur_d = rd_prev; rd_addr = rd_prev; steps_d = '0;
          end else begin
            cur_d = rd_next; rd_addr = rd_next; steps_d = steps_q - 1'b1;
          end
          state_d = SWaitA;
        end else if (ins_q) begin
          p_d = cur_q; n_d = rd_next; state_d = SIns;
        end else begin
          p_d = rd_prev; n_d = rd_next;
          rsp_d.removed_value = rd_val;
          state_d = SDel;
        end
      end
      SIns: begin
        // write new node and its links, then fix neighbours
        val_we = 1'b1;
        nxt_we = 1'b1; nxt_addr = new_slot; nxt_data = n_q;
        prv_we = 1'b1; prv_addr = new_slot; prv_data = p_q;
        state_d = SRdB;
      end
      SRdB: begin
        if (len_q != '0) begin
          nxt_we = 1'b1; nxt_addr = p_q; nxt_data = new_slot;
          prv_we = 1'b1; prv_addr = n_q; prv_data = new_slot;
        end
        if (len_q == '0 || func_q == FnInsFront ||
            (func_q == FnInsAt && pos_q == '0)) head_d = new_slot;
        free_d[new_slot] = 1'b0;
        len_d = len_q + 1'b1;
        rsp_d.element_count = len_q + 1'b1;
        state_d = SDone;
      end
      SDel: begin
        if (len_q == CountW'(1)) begin
          head_d = '0;
        end else begin
          nxt_we = 1'b1; nxt_addr = p_q; nxt_data = n_q;
          prv_we = 1'b1; prv_addr = n_q; prv_data = p_q;
          if (cur_q == head_q) head_d = n_q;
        end
        free_d[cur_q] = 1'b1;
        len_d = len_q - 1'b1;
        rsp_d.element_count = len_q - 1'b1;
        state_d = SWaitB;
      end
      SWaitB: state_d = SDone;
      SDone: begin
        // hand over once the output register is free or being emptied
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      free_q      <= '1;
      head_q      <= '0;
      len_q       <= '0;
      rsp_valid_q <= 1'b0;
      ins_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      head_q  <= head_d;
      len_q   <= len_d;
      ins_q   <= ins_d;
      if (rsp_load) rsp_valid_q <= 1'b1;
      else if (rsp_o.ready) rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      func_q <= req_i.data.func;
      pos_q  <= req_i.data.position;
      val_q  <= req_i.data.value;
    end
    if (rsp_load) rsp_out_q <= rsp_q;
    cur_q   <= cur_d;
    steps_q <= steps_d;
    p_q     <= p_d;
    n_q     <= n_d;
    rsp_q   <= rsp_d;
  end

endmodule
